>>> sv/assert_macros.svh
// assertion macros for the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, masked while reset is high
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// clocked check that also holds during reset
`define ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

>>> sv/qpc_pkg.sv
package qpc_pkg;

  // class codes of a result word
  localparam logic [1:0] CLASS_OBJID     = 2'd0;
  localparam logic [1:0] CLASS_CONDITION = 2'd1;
  localparam logic [1:0] CLASS_TRAVERSAL = 2'd2;
  localparam logic [1:0] CLASS_EXCEPTION = 2'd3;

  // tokenizer phase codes
  localparam logic [1:0] PH_BETWEEN = 2'd0;
  localparam logic [1:0] PH_TOKEN   = 2'd1;
  localparam logic [1:0] PH_QUOTE   = 2'd2;

  // keyword prefix match codes
  localparam logic [2:0] KW_IDLE = 3'd0;
  localparam logic [2:0] KW_A    = 3'd1;
  localparam logic [2:0] KW_AN   = 3'd2;
  localparam logic [2:0] KW_O    = 3'd3;
  localparam logic [2:0] KW_N    = 3'd4;
  localparam logic [2:0] KW_NO   = 3'd5;

  // character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_STAR  = 8'h2a;

  localparam logic [2:0] OBJID_LAST = 3'd5;

  // characters of the object id marker, by match position
  function automatic logic [7:0] objid_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = "s";
      3'd1:    ch = "t";
      3'd2:    ch = "r";
      3'd3:    ch = "o";
      3'd4:    ch = "i";
      3'd5:    ch = "d";
      default: ch = 8'hff;
    endcase
    return ch;
  endfunction

  function automatic logic is_operator(input logic [7:0] ch);
    return (ch == "!") || (ch == "=") || (ch == "<") || (ch == ">") ||
           (ch == "&") || (ch == "|");
  endfunction

endpackage

>>> sv/query_predicate_classifier_top.sv
// Query string classifier. Characters arrive one word per cycle on the input
// channel while in_ready is high; a NUL ends the string and, in the cycle after
// it is accepted, a class code (0 object id, 1 condition, 2 traversal
// wildcard, 3 exception) is presented on the output channel. The per-string
// flags are updated by a single level of logic from each accepted word. Non-NUL
// characters are accepted even while a result waits to be
// taken; a NUL waits only until the output register is free. The mode
// register (reset 1, predicate classification) is sampled at the NUL.
module query_predicate_classifier_top (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] char_code,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] class_code,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       predicate_mode
);

  logic       mode;
  logic [1:0] char_position, char_position_next;
  logic       first_is_star, first_is_star_next;
  logic       operator_seen, operator_seen_next;
  logic       keyword_seen, keyword_seen_next;
  logic [1:0] scan_phase, scan_phase_next;
  logic [2:0] keyword_progress, keyword_progress_next;
  logic [2:0] objid_progress, objid_progress_next;
  logic       objid_seen, objid_seen_next;
  logic       in_fire;
  logic       is_nul;
  logic [1:0] class_next;

  assign cfg_ready = 1'b1;
  assign is_nul    = (char_code == qpc_pkg::CH_NUL);
  assign in_ready  = !out_valid || out_ready || !is_nul;
  assign in_fire   = in_valid && in_ready;

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= 1'b1;
    end else if (cfg_valid) begin
      mode <= predicate_mode;
    end
  end

  // per-character flag update
  always_comb begin
    char_position_next    = (char_position < 2'd2) ? char_position + 2'd1 : char_position;
    first_is_star_next    = first_is_star ||
                            ((char_position == 2'd0) && (char_code == qpc_pkg::CH_STAR));
    operator_seen_next    = operator_seen || qpc_pkg::is_operator(char_code);
    keyword_seen_next     = keyword_seen;
    scan_phase_next       = scan_phase;
    keyword_progress_next = keyword_progress;

    // tokenizer and keyword prefix match
    unique case (scan_phase)
      qpc_pkg::PH_QUOTE: begin
        if (char_code == qpc_pkg::CH_QUOTE) scan_phase_next = qpc_pkg::PH_BETWEEN;
      end
      qpc_pkg::PH_TOKEN: begin
        keyword_progress_next = qpc_pkg::KW_IDLE;
        if (char_code == qpc_pkg::CH_SPACE) begin
          scan_phase_next = qpc_pkg::PH_BETWEEN;
        end else begin
          unique case (keyword_progress)
            qpc_pkg::KW_A:  if (char_code == "N") keyword_progress_next = qpc_pkg::KW_AN;
            qpc_pkg::KW_AN: if (char_code == "D") keyword_seen_next = 1'b1;
            qpc_pkg::KW_O:  if (char_code == "R") keyword_seen_next = 1'b1;
            qpc_pkg::KW_N:  if (char_code == "O") keyword_progress_next = qpc_pkg::KW_NO;
            qpc_pkg::KW_NO: if (char_code == "T") keyword_seen_next = 1'b1;
            default: ;
          endcase
        end
      end
      default: begin
        if (char_code == qpc_pkg::CH_QUOTE) begin
          scan_phase_next = qpc_pkg::PH_QUOTE;
        end else if (char_code != qpc_pkg::CH_SPACE) begin
          scan_phase_next = qpc_pkg::PH_TOKEN;
          if (char_code == "A")      keyword_progress_next = qpc_pkg::KW_A;
          else if (char_code == "O") keyword_progress_next = qpc_pkg::KW_O;
          else if (char_code == "N") keyword_progress_next = qpc_pkg::KW_N;
          else                       keyword_progress_next = qpc_pkg::KW_IDLE;
        end
      end
    endcase

    // object id substring match
    objid_seen_next = objid_seen;
    if (char_code == qpc_pkg::objid_char(objid_progress)) begin
      if (objid_progress == qpc_pkg::OBJID_LAST) begin
        objid_seen_next     = 1'b1;
        objid_progress_next = 3'd0;
      end else begin
        objid_progress_next = objid_progress + 3'd1;
      end
    end else begin
      objid_progress_next = (char_code == "s") ? 3'd1 : 3'd0;
    end
  end

  // classification at the terminator
  always_comb begin
    if ((char_position == 2'd1) && first_is_star)   class_next = qpc_pkg::CLASS_TRAVERSAL;
    else if (mode && (char_position == 2'd0))       class_next = qpc_pkg::CLASS_TRAVERSAL;
    else if (operator_seen || keyword_seen)         class_next = qpc_pkg::CLASS_CONDITION;
    else if (mode && objid_seen)                    class_next = qpc_pkg::CLASS_OBJID;
    else                                            class_next = qpc_pkg::CLASS_EXCEPTION;
  end

  // string state registers, cleared by reset and after each terminator
  always_ff @(posedge clk) begin
    if (rst || (in_fire && is_nul)) begin
      char_position    <= 2'd0;
      first_is_star    <= 1'b0;
      operator_seen    <= 1'b0;
      keyword_seen     <= 1'b0;
      scan_phase       <= qpc_pkg::PH_BETWEEN;
      keyword_progress <= qpc_pkg::KW_IDLE;
      objid_progress   <= 3'd0;
      objid_seen       <= 1'b0;
    end else if (in_fire) begin
      char_position    <= char_position_next;
      first_is_star    <= first_is_star_next;
      operator_seen    <= operator_seen_next;
      keyword_seen     <= keyword_seen_next;
      scan_phase       <= scan_phase_next;
      keyword_progress <= keyword_progress_next;
      objid_progress   <= objid_progress_next;
      objid_seen       <= objid_seen_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire && is_nul) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && is_nul) begin
      class_code <= class_next;
    end
  end

endmodule

>>> sv/qpc_checker.sv
`include "assert_macros.svh"

module qpc_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] char_code,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] class_code
);

  // a stalled result word holds
  `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(class_code))
  // a terminator yields a result in the next cycle
  `ASSERT_CLK(a_nul_result, in_valid && in_ready && char_code == qpc_pkg::CH_NUL |=> out_valid)
  // an ordinary character never creates a result
  `ASSERT_CLK(a_char_silent,
    in_valid && in_ready && char_code != qpc_pkg::CH_NUL && !(out_valid && !out_ready)
    |=> !out_valid)
  // reset empties the result register
  `ASSERT_RST(a_reset_empty, rst |=> !out_valid)

endmodule

bind query_predicate_classifier_top qpc_checker u_qpc_checker (.*);

>>> tb/query_predicate_classifier_top_tb.sv
module query_predicate_classifier_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DIR_N = 22;
  localparam int SEGMENT_CHARS = 80;
  localparam logic [47:0] OBJID_TEXT = "stroid";
  localparam string OP_CHARS = "!=<>&|";

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] char_code = qpc_pkg::CH_NUL;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [1:0] class_code;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       predicate_mode = 1'b1;

  // typed expectation that rides along with a terminating word
  bit         nul_typed = 1'b0;
  logic [1:0] nul_class = qpc_pkg::CLASS_EXCEPTION;

  int sender_idle_pct = 0;
  int sink_stall_pct = 0;
  int fail_count = 0;
  int cycle_count = 0;

  // classifier state mirrored by the testbench
  logic       mode_copy = 1'b1;
  logic [1:0] str_len;
  logic       star_first;
  logic       op_hit;
  logic       kw_hit;
  logic [1:0] phase;
  logic [2:0] kw_state;
  logic [2:0] oid_pos;
  logic       oid_hit;

  logic [1:0] class_expected[$];
  logic [7:0] query_chars[$];

  // directed strings
  string      dir_text [DIR_N];
  bit         dir_mode [DIR_N];
  bit         dir_typed[DIR_N];
  logic [1:0] dir_class[DIR_N];

  query_predicate_classifier_top uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .char_code(char_code),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .class_code(class_code),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .predicate_mode(predicate_mode)
  );

  always #10 clk = ~clk;

  function automatic bit op_char(input logic [7:0] ch);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < OP_CHARS.len(); i++) begin
      if (ch == OP_CHARS[i]) hit = 1'b1;
    end
    return hit;
  endfunction

  task automatic clear_string();
    str_len = 2'd0;
    star_first = 1'b0;
    op_hit = 1'b0;
    kw_hit = 1'b0;
    phase = qpc_pkg::PH_BETWEEN;
    kw_state = qpc_pkg::KW_IDLE;
    oid_pos = 3'd0;
    oid_hit = 1'b0;
  endtask

  // advance the mirrored state by one accepted character
  task automatic track_char(input logic [7:0] ch);
    logic [1:0] cls;
    logic [2:0] kw_next;
    if (ch == qpc_pkg::CH_NUL) begin
      if (str_len == 2'd1 && star_first) cls = qpc_pkg::CLASS_TRAVERSAL;
      else if (mode_copy && str_len == 2'd0) cls = qpc_pkg::CLASS_TRAVERSAL;
      else if (op_hit || kw_hit) cls = qpc_pkg::CLASS_CONDITION;
      else if (mode_copy && oid_hit) cls = qpc_pkg::CLASS_OBJID;
      else cls = qpc_pkg::CLASS_EXCEPTION;
      class_expected.push_back(nul_typed ? nul_class : cls);
      clear_string();
    end else begin
      if (str_len == 2'd0 && ch == qpc_pkg::CH_STAR) star_first = 1'b1;
      if (str_len < 2'd2) str_len = str_len + 2'd1;
      if (op_char(ch)) op_hit = 1'b1;
      // token and keyword tracking
      case (phase)
        qpc_pkg::PH_QUOTE: begin
          if (ch == qpc_pkg::CH_QUOTE) phase = qpc_pkg::PH_BETWEEN;
        end
        qpc_pkg::PH_TOKEN: begin
          if (ch == qpc_pkg::CH_SPACE) begin
            phase = qpc_pkg::PH_BETWEEN;
            kw_state = qpc_pkg::KW_IDLE;
          end else begin
            kw_next = qpc_pkg::KW_IDLE;
            case (kw_state)
              qpc_pkg::KW_A:  if (ch == "N") kw_next = qpc_pkg::KW_AN;
              qpc_pkg::KW_AN: if (ch == "D") kw_hit = 1'b1;
              qpc_pkg::KW_O:  if (ch == "R") kw_hit = 1'b1;
              qpc_pkg::KW_N:  if (ch == "O") kw_next = qpc_pkg::KW_NO;
              qpc_pkg::KW_NO: if (ch == "T") kw_hit = 1'b1;
              default:        kw_next = qpc_pkg::KW_IDLE;
            endcase
            kw_state = kw_next;
          end
        end
        default: begin
          if (ch == qpc_pkg::CH_QUOTE) begin
            phase = qpc_pkg::PH_QUOTE;
          end else if (ch != qpc_pkg::CH_SPACE) begin
            phase = qpc_pkg::PH_TOKEN;
            if (ch == "A") kw_state = qpc_pkg::KW_A;
            else if (ch == "O") kw_state = qpc_pkg::KW_O;
            else if (ch == "N") kw_state = qpc_pkg::KW_N;
            else kw_state = qpc_pkg::KW_IDLE;
          end
        end
      endcase
      // object id substring match
      if (ch == OBJID_TEXT[47 - 8 * oid_pos -: 8]) begin
        oid_pos = oid_pos + 3'd1;
        if (oid_pos == 3'd6) begin
          oid_hit = 1'b1;
          oid_pos = 3'd0;
        end
      end else begin
        oid_pos = (ch == "s") ? 3'd1 : 3'd0;
      end
    end
  endtask

  // watch both channels and the config port
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) mode_copy = predicate_mode;
      if (in_valid && in_ready) track_char(char_code);
      if (out_valid && out_ready) begin
        if (class_expected.size() == 0) begin
          $error("class_code: no word expected, got %0d", class_code);
          fail_count++;
        end else begin
          if (class_code !== class_expected[0]) begin
            $error("class_code: expected %0d, got %0d", class_expected[0], class_code);
            fail_count++;
          end
          void'(class_expected.pop_front());
        end
      end
    end
  end

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_char(input logic [7:0] ch, input bit typed, input logic [1:0] cls);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    char_code <= ch;
    nul_typed <= typed;
    nul_class <= cls;
    do @(posedge clk); while (!in_ready);
  endtask

  // send the pending characters and a terminating word
  task automatic send_query(input bit typed, input logic [1:0] cls, inout int sent);
    while (query_chars.size() != 0) begin
      send_char(query_chars.pop_front(), 1'b0, qpc_pkg::CLASS_EXCEPTION);
      sent++;
    end
    send_char(qpc_pkg::CH_NUL, typed, cls);
    sent++;
  endtask

  // hold off until every expected word has arrived
  task automatic drain();
    in_valid <= 1'b0;
    // let the monitor see the last accepted word first
    @(posedge clk);
    while (class_expected.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    drain();
    cfg_valid <= 1'b1;
    predicate_mode <= m;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) query_chars.push_back(s[i]);
  endtask

  // mostly token-shaped strings with random content, some raw bytes
  task automatic build_random_query();
    int pieces;
    pieces = $urandom_range(0, 6);
    if ($urandom_range(7) == 0) begin
      if ($urandom_range(1)) add_text("*");
    end else begin
      for (int p = 0; p < pieces; p++) begin
        case ($urandom_range(0, 15))
          0:  add_text(" ");
          1:  add_text("\"");
          2:  add_text("AND");
          3:  add_text("OR");
          4:  add_text("NOT");
          5:  add_text("stroid");
          6:  add_text("stro");
          7:  query_chars.push_back(OP_CHARS[$urandom_range(0, 5)]);
          8: begin
            case ($urandom_range(0, 2))
              0:       add_text("AN");
              1:       add_text("NO");
              default: add_text("O");
            endcase
          end
          9:  add_text("*");
          13: query_chars.push_back(8'($urandom_range(1, 255)));
          14: add_text("s");
          15: add_text("id");
          default: query_chars.push_back(8'($urandom_range(97, 122)));
        endcase
      end
    end
  endtask

  initial begin
    int sent;
    int seg_sent;
    dir_text  = '{"", "*", "stroid", "a=b", "x!y<z>w&v|u", "\377\001", "AND x", "OR",
                  "NOTE", "AN NO O", "\"AND x", "\"q\"AND", "a\"OR",
                  "ss stroi strstroid", "  NOT  ", "", "*", "stroid", "**",
                  "xOR \"a b\" NOT", "\"a\" \"b\" OR", "*="};
    dir_mode  = '{1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0};
    dir_typed = '{1, 1, 1, 1, 0, 1, 1, 1, 0, 0, 0, 0, 0, 0, 0, 1, 1, 1, 0, 0, 0, 0};
    dir_class = '{qpc_pkg::CLASS_TRAVERSAL, qpc_pkg::CLASS_TRAVERSAL, qpc_pkg::CLASS_OBJID,
                  qpc_pkg::CLASS_CONDITION, qpc_pkg::CLASS_EXCEPTION,
                  qpc_pkg::CLASS_EXCEPTION, qpc_pkg::CLASS_CONDITION,
                  qpc_pkg::CLASS_CONDITION, qpc_pkg::CLASS_EXCEPTION,
                  qpc_pkg::CLASS_EXCEPTION, qpc_pkg::CLASS_EXCEPTION,
                  qpc_pkg::CLASS_EXCEPTION, qpc_pkg::CLASS_EXCEPTION,
                  qpc_pkg::CLASS_EXCEPTION, qpc_pkg::CLASS_EXCEPTION,
                  qpc_pkg::CLASS_EXCEPTION, qpc_pkg::CLASS_TRAVERSAL,
                  qpc_pkg::CLASS_EXCEPTION, qpc_pkg::CLASS_EXCEPTION,
                  qpc_pkg::CLASS_EXCEPTION, qpc_pkg::CLASS_EXCEPTION,
                  qpc_pkg::CLASS_EXCEPTION};
    sent = 0;
    clear_string();

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed strings, mode as reset leaves it until a row asks otherwise
    for (int i = 0; i < DIR_N; i++) begin
      if (dir_mode[i] != mode_copy) write_mode(dir_mode[i]);
      add_text(dir_text[i]);
      send_query(dir_typed[i], dir_class[i], sent);
    end

    // random strings over idling phases and mode settings
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: begin sender_idle_pct <= 0;  sink_stall_pct <= 0;  end
        1: begin sender_idle_pct <= 87; sink_stall_pct <= 0;  end
        2: begin sender_idle_pct <= 0;  sink_stall_pct <= 87; end
        default: begin sender_idle_pct <= 14; sink_stall_pct <= 14; end
      endcase
      for (int seg = 0; seg < 2; seg++) begin
        if (ph == 0) write_mode(seg[0]);
        else write_mode($urandom_range(1));
        seg_sent = 0;
        while (seg_sent < SEGMENT_CHARS) begin
          build_random_query();
          send_query(1'b0, qpc_pkg::CLASS_EXCEPTION, seg_sent);
        end
        sent += seg_sent;
      end
    end

    // wind down
    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> query_predicate_classifier_top.f
+incdir+sv
sv/qpc_pkg.sv
sv/query_predicate_classifier_top.sv
sv/qpc_checker.sv
tb/query_predicate_classifier_top_tb.sv
